/* hw/rtl/hbwa_pkg.sv */
// Shared types and constants for the highlight-boosted weighted average block.
// No dependencies; imported by the datapath, controller and top-level modules.
`default_nettype none
package hbwa_pkg;
    localparam int unsigned NUM_CH     = 4;
    localparam int unsigned SUM_BITS   = 64;
    localparam int unsigned TOT_BITS   = 48;
    localparam int unsigned THR_BITS   = 24;
    localparam int unsigned GAIN_BITS  = 16;
    localparam int unsigned CFG_BITS   = 24;
    localparam logic [16:0] LUMA_COEF_R = 17'd13933;
    localparam logic [16:0] LUMA_COEF_G = 17'd46871;
    localparam logic [16:0] LUMA_COEF_B = 17'd4732;
    localparam logic CFG_IDX_THRESHOLD = 1'b0;
    localparam logic CFG_IDX_GAIN      = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tap_load;   // capture an accepted tap
        logic luma;       // form luminance and boost factor
        logic boost;      // scale the weights
        logic accum;      // add into the accumulators
        logic div_start;  // load the dividers
        logic div_step;   // one quotient bit per channel
        logic div_done;   // round, saturate, present and clear
    } hbwa_cmd_t;

    // Status from the datapath.
    typedef struct packed {
        logic last;
    } hbwa_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/hbwa_datapath.sv */
// Datapath: tap registers, luminance, boost multipliers, accumulators and
// restoring dividers. Depends on hbwa_pkg; driven by hbwa_ctrl.
`default_nettype none
module hbwa_datapath
    import hbwa_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire hbwa_cmd_t              cmd,
    output hbwa_stat_t                  stat,
    input  wire logic [THR_BITS-1:0]    thr,
    input  wire logic [GAIN_BITS-1:0]   gain,
    input  wire logic [WEIGHT_BITS-1:0] w_in [NUM_CH],
    input  wire logic [SAMPLE_BITS-1:0] s_in [NUM_CH],
    input  wire logic                   last_in,
    output logic [SAMPLE_BITS-1:0]      res  [NUM_CH]
);
    localparam int unsigned LUM_BITS = SAMPLE_BITS + 17;
    localparam int unsigned EXC_BITS = SAMPLE_BITS + 1;
    localparam int unsigned FAC_BITS = EXC_BITS + GAIN_BITS + 1;
    localparam int unsigned PRD_BITS = WEIGHT_BITS + FAC_BITS;
    localparam int unsigned REM_BITS = TOT_BITS + 1;
    localparam logic [WEIGHT_BITS-1:0] WMAX = '1;
    localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

    logic [WEIGHT_BITS-1:0] w_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] s_reg [NUM_CH];
    logic                   last_reg;
    logic [LUM_BITS-1:0]    lr_reg, lg_reg, lb_reg;
    logic                   boost_reg;
    logic [FAC_BITS-1:0]    fac_reg;
    logic [SUM_BITS-1:0]    sum_reg [NUM_CH];
    logic [TOT_BITS-1:0]    tot_reg [NUM_CH];
    logic [SUM_BITS-1:0]    quo_reg [NUM_CH];
    logic [REM_BITS-1:0]    rem_reg [NUM_CH];

    assign stat.last = last_reg;

    // Luminance sum and excess over the threshold from the registered products.
    logic [LUM_BITS-1:0] lum_sum;
    logic [SAMPLE_BITS:0] lum;
    logic [EXC_BITS-1:0] exc;
    assign lum_sum = lr_reg + lg_reg + lb_reg + LUM_BITS'(32768);
    assign lum = lum_sum[LUM_BITS-1:16];
    assign exc = EXC_BITS'(lum) - EXC_BITS'(thr);

    // Tap capture, luminance products and the boosted weight, which is
    // w*F/2^24 rounded half up and saturated.
    always_ff @(posedge clk)
    begin
        if (cmd.tap_load)
        begin
            w_reg    <= w_in;
            s_reg    <= s_in;
            last_reg <= last_in;
        end
        else if (cmd.boost && boost_reg)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                logic [PRD_BITS-1:0] p;
                logic [PRD_BITS-1:0] q;
                p = PRD_BITS'(w_reg[c]) * PRD_BITS'(fac_reg) + (PRD_BITS'(1) << 23);
                q = p >> 24;
                w_reg[c] <= (q > PRD_BITS'(WMAX)) ? WMAX : q[WEIGHT_BITS-1:0];
            end
        end
        if (cmd.luma)
        begin
            lr_reg <= LUM_BITS'(s_reg[0]) * LUM_BITS'(LUMA_COEF_R);
            lg_reg <= LUM_BITS'(s_reg[1]) * LUM_BITS'(LUMA_COEF_G);
            lb_reg <= LUM_BITS'(s_reg[2]) * LUM_BITS'(LUMA_COEF_B);
        end
    end

    // Boost factor register, one stage after the luminance products.
    logic luma_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            luma_d_reg <= 1'b0;
        else
            luma_d_reg <= cmd.luma;
    end

    always_ff @(posedge clk)
    begin
        if (luma_d_reg)
        begin
            boost_reg <= (lum > (SAMPLE_BITS+1)'(thr));
            fac_reg   <= (FAC_BITS'(1) << 24) + FAC_BITS'(gain) * FAC_BITS'(exc);
        end
    end

    // Accumulators with saturation; each channel's divider has its own quotient register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                sum_reg[c] <= '0;
                tot_reg[c] <= '0;
            end
        end
        else if (cmd.accum)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                logic [SUM_BITS:0] s;
                logic [TOT_BITS:0] t;
                s = {1'b0, sum_reg[c]} +
                    (SUM_BITS+1)'(w_reg[c]) * (SUM_BITS+1)'(s_reg[c]);
                t = {1'b0, tot_reg[c]} + (TOT_BITS+1)'(w_reg[c]);
                sum_reg[c] <= s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
                tot_reg[c] <= t[TOT_BITS] ? '1 : t[TOT_BITS-1:0];
            end
        end
        else if (cmd.div_done)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                sum_reg[c] <= '0;
                tot_reg[c] <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per cycle for each channel.
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                quo_reg[c] <= sum_reg[c];
                rem_reg[c] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                logic [REM_BITS-1:0] r;
                r = {rem_reg[c][REM_BITS-2:0], quo_reg[c][SUM_BITS-1]};
                if (r >= REM_BITS'(tot_reg[c]))
                begin
                    rem_reg[c] <= r - REM_BITS'(tot_reg[c]);
                    quo_reg[c] <= {quo_reg[c][SUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= r;
                    quo_reg[c] <= {quo_reg[c][SUM_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Rounding, saturation and output word register.
    always_ff @(posedge clk)
    begin
        if (cmd.div_done)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                logic [SUM_BITS:0] q;
                logic [REM_BITS-1:0] half;
                half = REM_BITS'(tot_reg[c]) - rem_reg[c];
                q = {1'b0, quo_reg[c]} + (SUM_BITS+1)'(rem_reg[c] >= half);
                if (tot_reg[c] == '0)
                    res[c] <= '0;
                else
                    res[c] <= (q > (SUM_BITS+1)'(SMAX)) ? SMAX : q[SAMPLE_BITS-1:0];
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/hbwa_ctrl.sv */
// Controller state machine: sequences tap capture, boost, accumulate and
// the final division. Depends on hbwa_pkg.
`default_nettype none
module hbwa_ctrl
    import hbwa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire hbwa_stat_t stat,
    output hbwa_cmd_t       cmd
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LUMA  = 6'b000010,
        ST_FACT  = 6'b000100,
        ST_BOOST = 6'b001000,
        ST_ACCUM = 6'b010000,
        ST_DIV   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;

    // Accept only when idle; a waiting result word sits in its own register.
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.tap_load = 1'b1;
                    state_next   = ST_LUMA;
                end
            end
            ST_LUMA:
            begin
                cmd.luma   = 1'b1;
                state_next = ST_FACT;
            end
            ST_FACT:  state_next = ST_BOOST;
            ST_BOOST:
            begin
                cmd.boost  = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (stat.last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                // Load after the accumulators settle, 64 steps, then present.
                if (cnt_reg == 7'd0)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = cnt_reg + 7'd1;
                end
                else if (cnt_reg == 7'd65)
                begin
                    if (!(ov_reg && out_stall))
                    begin
                        cmd.div_done = 1'b1;
                        ov_next      = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 7'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/highlight_boosted_weighted_average.sv */
// A tap passes through capture, luminance products, boost factor, boost
// multiply and accumulate, and no new tap is accepted until the one before
// it is accumulated. A last tap then loads the four parallel channel dividers,
// runs 64 restoring steps, and rounds and presents the word, which waits
// while an earlier result word is still stalled. Reset clears the controller
// and accumulators and sets the configuration registers to their defaults.
`default_nettype none
module highlight_boosted_weighted_average
    import hbwa_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [0:0]             cfg_index,
    input  wire logic [CFG_BITS-1:0]    cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [WEIGHT_BITS-1:0] weight_red,
    input  wire logic [WEIGHT_BITS-1:0] weight_green,
    input  wire logic [WEIGHT_BITS-1:0] weight_blue,
    input  wire logic [WEIGHT_BITS-1:0] weight_alpha,
    input  wire logic [SAMPLE_BITS-1:0] sample_red,
    input  wire logic [SAMPLE_BITS-1:0] sample_green,
    input  wire logic [SAMPLE_BITS-1:0] sample_blue,
    input  wire logic [SAMPLE_BITS-1:0] sample_alpha,
    input  wire logic                   last_tap,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [SAMPLE_BITS-1:0]      result_red,
    output logic [SAMPLE_BITS-1:0]      result_green,
    output logic [SAMPLE_BITS-1:0]      result_blue,
    output logic [SAMPLE_BITS-1:0]      result_alpha
);
    logic [THR_BITS-1:0]  thr_reg;
    logic [GAIN_BITS-1:0] gain_reg;
    hbwa_cmd_t  cmd;
    hbwa_stat_t stat;
    logic [WEIGHT_BITS-1:0] w_in [NUM_CH];
    logic [SAMPLE_BITS-1:0] s_in [NUM_CH];
    logic [SAMPLE_BITS-1:0] res  [NUM_CH];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= '1;
            gain_reg <= GAIN_BITS'(256);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IDX_THRESHOLD)
                thr_reg <= cfg_data[THR_BITS-1:0];
            else if (cfg_index == CFG_IDX_GAIN)
                gain_reg <= cfg_data[GAIN_BITS-1:0];
        end
    end

    assign w_in = '{weight_red, weight_green, weight_blue, weight_alpha};
    assign s_in = '{sample_red, sample_green, sample_blue, sample_alpha};
    assign result_red   = res[0];
    assign result_green = res[1];
    assign result_blue  = res[2];
    assign result_alpha = res[3];

    hbwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hbwa_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .thr     (thr_reg),
        .gain    (gain_reg),
        .w_in    (w_in),
        .s_in    (s_in),
        .last_in (last_tap),
        .res     (res)
    );
endmodule
`default_nettype wire

/* hw/rtl/hbwa_checker.sv */
// Port-level checker for the highlight-boosted weighted average block,
// bound to the top level. Depends only on the top level's ports.
`default_nettype none
module hbwa_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic last_tap
);
    // One tap is worked on at a time; the input stays stalled after a tap is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall [*4]) else $error("second tap too early");

    // A tap that is not last does not raise a result when it is done.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !last_tap) |=> ##4 !$rose(out_valid))
        else $error("result without last tap");

    // A stalled result stays.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

bind highlight_boosted_weighted_average hbwa_checker u_hbwa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last_tap  (last_tap)
);
`default_nettype wire
